### rtl/imu_fp_pkg.sv
// shared types and constants of the imu frame parser
package imu_fp_pkg;

  // buffer and frame geometry
  localparam int FRAMES_PER_BUFFER = 9;
  localparam int FRAME_BYTES       = 11;
  localparam int FC_W              = $clog2(FRAMES_PER_BUFFER + 1);
  localparam int POS_W             = 4;

  localparam logic [POS_W-1:0] POS_HEAD  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TYPE  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);

  // frame type bytes on the wire
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [7:0] TYPE_MAG   = 8'h54;
  localparam logic [7:0] TYPE_QUAT  = 8'h59;

  // configuration register indexes and reset values
  localparam logic [1:0] CFG_HEAD = 2'd0;
  localparam logic [1:0] CFG_SEL  = 2'd1;
  localparam logic [1:0] CFG_NEG  = 2'd2;

  localparam logic [7:0] HEAD_RST = 8'h55;
  localparam logic [5:0] SEL_RST  = 6'd36;
  localparam logic [2:0] NEG_RST  = 3'd2;

  // saturation limits and yaw turn constants
  localparam logic signed [15:0] WORD_MAX = 16'sh7fff;
  localparam logic signed [15:0] WORD_MIN = 16'sh8000;
  localparam logic signed [32:0] YAW_MAX  = 33'sh0_7fff_ffff;
  localparam logic signed [32:0] YAW_MIN  = 33'sh1_8000_0000;
  localparam logic signed [17:0] HALF_TURN = 18'sd32768;
  localparam logic signed [17:0] FULL_TURN = 18'sd65536;

  typedef enum logic [2:0] {
    KIND_ACCEL = 3'd0,
    KIND_GYRO  = 3'd1,
    KIND_ANGLE = 3'd2,
    KIND_MAG   = 3'd3,
    KIND_QUAT  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] head;
    logic [5:0] sel;
    logic [2:0] neg;
  } cfg_t;

  // one complete frame: kind and raw payload, byte k at bits 8k
  typedef struct packed {
    kind_t       kind;
    logic [63:0] payload;
  } frame_t;

  // remapped components of one frame
  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] c0;
    logic signed [15:0] c1;
    logic signed [15:0] c2;
    logic signed [15:0] c3;
  } comp_t;

endpackage

### rtl/imu_fp_if.sv
// valid/ready channel interfaces for bytes in and results out
interface imu_fp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_start;

  modport source (output valid, output rx_byte, output buffer_start, input ready);
  modport sink   (input valid, input rx_byte, input buffer_start, output ready);
endinterface

interface imu_fp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         frame_kind;
  logic signed [15:0] comp_zero;
  logic signed [15:0] comp_one;
  logic signed [15:0] comp_two;
  logic signed [15:0] comp_three;
  logic signed [31:0] yaw_total;

  modport source (output valid, output frame_kind, output comp_zero, output comp_one,
                  output comp_two, output comp_three, output yaw_total, input ready);
  modport sink   (input valid, input frame_kind, input comp_zero, input comp_one,
                  input comp_two, input comp_three, input yaw_total, output ready);
endinterface

### rtl/imu_fp_parser.sv
// byte-wise frame parser: head check, type, payload assembly, buffer bookkeeping
module imu_fp_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  imu_fp_in_if.sink            in_s,
  input  logic [7:0]           head_byte,
  output logic                 frm_valid,
  output imu_fp_pkg::frame_t   frm,
  input  logic                 frm_ready
);
  import imu_fp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [FC_W-1:0]  cnt_r, cnt_nxt;
  logic             ab_r, ab_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [63:0]      pay_r, pay_nxt;
  logic             fv_r, fv_nxt;
  frame_t           f_r, f_nxt;
  logic             fire;
  logic             emit;
  kind_t            kind;
  logic             known;
  logic [FC_W-1:0]  cnt_inc;

  // a byte may enter whenever the frame register is free or moving on
  assign in_s.ready = !fv_r || frm_ready;
  assign fire       = in_s.valid && in_s.ready;

  // type byte decode
  always_comb begin
    known = 1'b1;
    kind  = KIND_ACCEL;
    case (type_r)
      TYPE_ACCEL: kind = KIND_ACCEL;
      TYPE_GYRO:  kind = KIND_GYRO;
      TYPE_ANGLE: kind = KIND_ANGLE;
      TYPE_MAG:   kind = KIND_MAG;
      TYPE_QUAT:  kind = KIND_QUAT;
      default:    known = 1'b0;
    endcase
  end

  // parse step for one accepted beat
  always_comb begin
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    ab_nxt   = ab_r;
    type_nxt = type_r;
    pay_nxt  = pay_r;
    emit     = 1'b0;
    cnt_inc  = '0;
    if (fire) begin
      if (in_s.buffer_start) begin
        pos_nxt = POS_HEAD;
        cnt_nxt = '0;
        ab_nxt  = 1'b0;
      end
      if (!ab_nxt) begin
        if (pos_nxt == POS_HEAD) begin
          if (in_s.rx_byte != head_byte) ab_nxt = 1'b1;
          else pos_nxt = POS_TYPE;
        end else if (pos_nxt == POS_TYPE) begin
          type_nxt = in_s.rx_byte;
          pos_nxt  = POS_FIRST;
        end else if (pos_nxt < POS_LAST) begin
          // eight payload bytes shift in, first byte ends up lowest
          pay_nxt = {in_s.rx_byte, pay_r[63:8]};
          pos_nxt = pos_nxt + POS_W'(1);
        end else begin
          // checksum byte closes the frame
          cnt_inc = cnt_nxt + FC_W'(1);
          pos_nxt = POS_HEAD;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= FC_W'(FRAMES_PER_BUFFER)) ab_nxt = 1'b1;
          emit = known;
        end
      end
    end
  end

  // frame register handoff
  always_comb begin
    fv_nxt = fv_r;
    f_nxt  = f_r;
    if (frm_ready) fv_nxt = 1'b0;
    if (emit) begin
      fv_nxt       = 1'b1;
      f_nxt.kind    = kind;
      f_nxt.payload = pay_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HEAD;
      cnt_r  <= '0;
      ab_r   <= 1'b0;
      type_r <= '0;
      pay_r  <= '0;
      fv_r   <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
      ab_r   <= ab_nxt;
      type_r <= type_nxt;
      pay_r  <= pay_nxt;
      fv_r   <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt;
  end

  assign frm_valid = fv_r;
  assign frm       = f_r;

endmodule

### rtl/imu_fp_remap.sv
// axis source selection and saturating sign flip of one frame
module imu_fp_remap (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [5:0]          sel,
  input  logic [2:0]          neg,
  input  logic                frm_valid,
  input  imu_fp_pkg::frame_t  frm,
  output logic                frm_ready,
  output logic                cmp_valid,
  output imu_fp_pkg::comp_t   cmp,
  input  logic                cmp_ready
);
  import imu_fp_pkg::*;

  logic               cv_r, cv_nxt;
  comp_t              c_r, c_nxt;
  logic signed [15:0] w [4];
  logic signed [15:0] src [4];
  logic signed [15:0] m [3];

  assign frm_ready = !cv_r || cmp_ready;

  // split payload into words, angle swaps the first two
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w[i]   = frm.payload[16*i +: 16];
      src[i] = w[i];
    end
    if (frm.kind == KIND_ANGLE) begin
      src[0] = w[1];
      src[1] = w[0];
    end
    for (int i = 0; i < 3; i++) begin
      m[i] = src[sel[2*i +: 2]];
      if (neg[i]) m[i] = (m[i] == WORD_MIN) ? WORD_MAX : -m[i];
    end
  end

  // pick mapped or raw components
  always_comb begin
    c_nxt.kind = frm.kind;
    if (frm.kind == KIND_ACCEL || frm.kind == KIND_GYRO || frm.kind == KIND_ANGLE) begin
      c_nxt.c0 = m[0];
      c_nxt.c1 = m[1];
      c_nxt.c2 = m[2];
    end else begin
      c_nxt.c0 = w[0];
      c_nxt.c1 = w[1];
      c_nxt.c2 = w[2];
    end
    c_nxt.c3 = (frm.kind == KIND_QUAT) ? w[3] : '0;
  end

  always_comb begin
    cv_nxt = cv_r;
    if (cmp_ready) cv_nxt = 1'b0;
    if (frm_valid && frm_ready) cv_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else begin
      cv_r <= cv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_valid && frm_ready) begin
      c_r <= c_nxt;
    end
  end

  assign cmp_valid = cv_r;
  assign cmp       = c_r;

endmodule

### rtl/imu_fp_yaw.sv
// yaw unwrap into a saturating total and the output register
module imu_fp_yaw (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmp_valid,
  input  imu_fp_pkg::comp_t  cmp,
  output logic               cmp_ready,
  imu_fp_out_if.source       out_m
);
  import imu_fp_pkg::*;

  logic               ov_r, ov_nxt;
  comp_t              oc_r;
  logic signed [31:0] oy_r, oy_nxt;
  logic signed [15:0] last_r, last_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic               seed_r, seed_nxt;
  logic signed [17:0] d0, d;
  logic signed [32:0] sum;
  logic               load;

  assign cmp_ready = !ov_r || out_m.ready;
  assign load      = cmp_valid && cmp_ready;

  // delta folded into half a turn either way, then saturating add
  always_comb begin
    d0 = 18'(cmp.c2) - 18'(last_r);
    d  = d0;
    if (d0 > HALF_TURN) d = d0 - FULL_TURN;
    else if (d0 < -HALF_TURN) d = d0 + FULL_TURN;
    sum = 33'(acc_r) + 33'(d);
    if (sum > YAW_MAX) sum = YAW_MAX;
    else if (sum < YAW_MIN) sum = YAW_MIN;
  end

  // yaw state update on an angle beat
  always_comb begin
    last_nxt = last_r;
    acc_nxt  = acc_r;
    seed_nxt = seed_r;
    oy_nxt   = '0;
    if (load && cmp.kind == KIND_ANGLE) begin
      last_nxt = cmp.c2;
      seed_nxt = 1'b1;
      if (seed_r) begin
        acc_nxt = sum[31:0];
        oy_nxt  = sum[31:0];
      end else begin
        acc_nxt = '0;
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_m.ready) ov_nxt = 1'b0;
    if (load) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      last_r <= '0;
      acc_r  <= '0;
      seed_r <= 1'b0;
    end else begin
      ov_r   <= ov_nxt;
      last_r <= last_nxt;
      acc_r  <= acc_nxt;
      seed_r <= seed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      oc_r <= cmp;
      oy_r <= oy_nxt;
    end
  end

  assign out_m.valid      = ov_r;
  assign out_m.frame_kind = oc_r.kind;
  assign out_m.comp_zero  = oc_r.c0;
  assign out_m.comp_one   = oc_r.c1;
  assign out_m.comp_two   = oc_r.c2;
  assign out_m.comp_three = oc_r.c3;
  assign out_m.yaw_total  = oy_r;

endmodule

### rtl/imu_frame_parser_axis_remap.sv
// top level of the imu frame parser with axis remap
//
// Bytes of a serial imu stream enter on in_s, one per beat, with buffer_start
// set on the first byte of each buffer. Each buffer holds nine 11-byte frames.
// For every frame of known type one result leaves on out_m: the frame kind,
// up to four components and, for angle frames, the unwrapped yaw total.
// A wrong head byte or a full buffer makes the parser drop bytes until the
// next buffer start.
// Throughput: one byte per cycle while in_s.ready is high. The result passes
// through the frame register, remap register and output register after the
// edge that takes its checksum byte.
// A stalled out_m holds its result; bytes keep flowing until the pipe is full,
// then in_s.ready drops until the receiver takes the waiting result.
// Synchronous reset clears parse and yaw state and loads the register
// defaults (head 0x55, source select 36, negate mask 2).
// cfg_we writes register cfg_index with cfg_data on the next edge; index 0 is
// the head byte, 1 the source select, 2 the negate mask, 3 is ignored.
module imu_frame_parser_axis_remap (
  input  logic         clk,
  input  logic         rst_n,
  imu_fp_in_if.sink    in_s,
  imu_fp_out_if.source out_m,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);
  import imu_fp_pkg::*;

  cfg_t   cfg_r;
  logic   frm_valid, frm_ready;
  frame_t frm;
  logic   cmp_valid, cmp_ready;
  comp_t  cmp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head <= HEAD_RST;
      cfg_r.sel  <= SEL_RST;
      cfg_r.neg  <= NEG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAD: cfg_r.head <= cfg_data;
        CFG_SEL:  cfg_r.sel  <= cfg_data[5:0];
        CFG_NEG:  cfg_r.neg  <= cfg_data[2:0];
        default:  ;
      endcase
    end
  end

  imu_fp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_s),
    .head_byte (cfg_r.head),
    .frm_valid (frm_valid),
    .frm       (frm),
    .frm_ready (frm_ready)
  );

  imu_fp_remap u_remap (
    .clk       (clk),
    .rst_n     (rst_n),
    .sel       (cfg_r.sel),
    .neg       (cfg_r.neg),
    .frm_valid (frm_valid),
    .frm       (frm),
    .frm_ready (frm_ready),
    .cmp_valid (cmp_valid),
    .cmp       (cmp),
    .cmp_ready (cmp_ready)
  );

  imu_fp_yaw u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmp_valid (cmp_valid),
    .cmp       (cmp),
    .cmp_ready (cmp_ready),
    .out_m     (out_m)
  );

endmodule

### rtl/imu_fp_checker.sv
// port-level checks of the imu frame parser, bound to the top level
module imu_fp_assert (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_kind,
  input logic signed [15:0] out_c3,
  input logic signed [31:0] out_yaw
);
  import imu_fp_pkg::*;

  // a result waiting on a stalled receiver stays up
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // only known kinds leave the block
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_ACCEL || out_kind == KIND_GYRO ||
                   out_kind == KIND_ANGLE || out_kind == KIND_MAG ||
                   out_kind == KIND_QUAT))
    else $error("unknown frame kind");

  // fourth word only on quaternion frames
  a_c3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_QUAT |-> out_c3 == '0)
    else $error("fourth word set on non-quaternion beat");

  // yaw total only on angle frames
  a_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ANGLE |-> out_yaw == '0)
    else $error("yaw total set on non-angle beat");

endmodule

bind imu_frame_parser_axis_remap imu_fp_assert u_assert (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_kind  (out_m.frame_kind),
  .out_c3    (out_m.comp_three),
  .out_yaw   (out_m.yaw_total)
);
